// File: hw/rtl/can_signal_field_pack_unpack_core_defines.svh
// ----------------------------------------------------------------------------
// CAN signal field pack/unpack core - assertion macros
// Clocked, reset-qualified property checks shared by the core.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_FIELD_PACK_UNPACK_CORE_DEFINES_SVH
`define CAN_SIGNAL_FIELD_PACK_UNPACK_CORE_DEFINES_SVH

// Same-cycle implication.
`define CSFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/csfp_pkg.sv
// ----------------------------------------------------------------------------
// csfp_pkg
// Types, codes and helper functions of the CAN signal field pack/unpack core.
// ----------------------------------------------------------------------------
`default_nettype none

package csfp_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BYTE_BITS  = 8;
    localparam int SHIFT_BITS = 6;
    localparam int LEN_BITS   = 7;

    localparam logic CMD_GET        = 1'b0;
    localparam logic CMD_SET        = 1'b1;
    localparam logic ORDER_INTEL    = 1'b0;
    localparam logic ORDER_MOTOROLA = 1'b1;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [SHIFT_BITS-1:0] bitpos_t;
    typedef logic [LEN_BITS-1:0]   len_t;

    // Decoded signal descriptor
    typedef struct packed {
        logic    err;
        logic    motorola;
        bitpos_t shift;
        word_t   mask;
    } desc_t;

    function automatic word_t byte_swap(input word_t w);
        word_t r;
        for (int i = 0; i < WORD_BITS / BYTE_BITS; i++)
        begin
            r[i*BYTE_BITS +: BYTE_BITS] = w[(WORD_BITS/BYTE_BITS-1-i)*BYTE_BITS +: BYTE_BITS];
        end
        return r;
    endfunction

    function automatic word_t low_mask(input len_t len);
        word_t r;
        if (len[LEN_BITS-1])
            r = '1;
        else
            r = ~({WORD_BITS{1'b1}} << len[SHIFT_BITS-1:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/csfp_desc.sv
// ----------------------------------------------------------------------------
// csfp_desc
// Decode start bit, length and byte order into shift, mask and range error.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_desc
    import csfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
)
(
    input  wire bitpos_t start_bit,
    input  wire len_t    bit_length,
    input  wire logic    byte_order,
    output desc_t        desc
);

    localparam logic [7:0] TOTAL_BITS = 8'(PAYLOAD_BYTES * BYTE_BITS);

    bitpos_t    first;
    logic [7:0] end_pos;
    logic [7:0] moto_shift;

    always_comb
    begin
        if (byte_order == ORDER_MOTOROLA)
            first = {start_bit[SHIFT_BITS-1:3], ~start_bit[2:0]};
        else
            first = start_bit;
        end_pos    = {2'b00, first} + {1'b0, bit_length};
        moto_shift = 8'(WORD_BITS) - end_pos;

        desc.err      = (bit_length == '0) || (bit_length > len_t'(WORD_BITS))
                        || (end_pos > TOTAL_BITS);
        desc.motorola = (byte_order == ORDER_MOTOROLA);
        desc.shift    = (byte_order == ORDER_MOTOROLA) ? moto_shift[SHIFT_BITS-1:0]
                                                       : start_bit;
        desc.mask     = low_mask(bit_length);
    end

endmodule

`default_nettype wire

// File: hw/rtl/csfp_field.sv
// ----------------------------------------------------------------------------
// csfp_field
// Extract or insert one signal field in a payload word.
// ----------------------------------------------------------------------------
`default_nettype none

module csfp_field
    import csfp_pkg::*;
(
    input  wire logic  cmd,
    input  wire word_t frame_in,
    input  wire word_t insert_value,
    input  wire desc_t desc,
    output word_t      signal_value,
    output word_t      frame_out
);

    word_t word;
    word_t field_mask;
    word_t updated;

    always_comb
    begin
        word       = desc.motorola ? byte_swap(frame_in) : frame_in;
        field_mask = desc.mask << desc.shift;
        updated    = (word & ~field_mask) | ((insert_value & desc.mask) << desc.shift);

        signal_value = '0;
        frame_out    = frame_in;
        if (!desc.err)
        begin
            if (cmd == CMD_GET)
                signal_value = (word >> desc.shift) & desc.mask;
            else
                frame_out = desc.motorola ? byte_swap(updated) : updated;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/can_signal_field_pack_unpack_core.sv
// ----------------------------------------------------------------------------
// can_signal_field_pack_unpack_core
// Raw get/set of one Intel or Motorola signal field in a CAN payload.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present cmd, frame_in, start_bit, bit_length, byte_order
//   and insert_value with start high; the transaction is taken at the clock
//   edge where start is high and busy is low. busy stays low, so a new
//   transaction may be issued on every cycle.
//   Result channel: done is high for exactly one cycle with signal_value,
//   frame_out and range_error valid; the receiver must take it then.
//   A result passes the input register, then the result register, before done
//   is raised. Throughput: 1 transaction per cycle, set by the single 64-bit
//   shift-and-mask stage.
//   A get returns the field in signal_value and the frame unchanged; a set
//   returns zero and the updated frame. An overrunning field raises
//   range_error with zero value and the frame unchanged.
//   Reset: rst_n clears the pipeline valid flags; transactions in flight
//   are dropped and no done is produced for them.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_signal_field_pack_unpack_core_defines.svh"

module can_signal_field_pack_unpack_core
    import csfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire logic    cmd,
    input  wire word_t   frame_in,
    input  wire bitpos_t start_bit,
    input  wire len_t    bit_length,
    input  wire logic    byte_order,
    input  wire word_t   insert_value,
    output logic         done,
    output word_t        signal_value,
    output word_t        frame_out,
    output logic         range_error
);

    logic    s1_valid_reg;
    logic    s1_cmd_reg;
    word_t   s1_frame_reg;
    bitpos_t s1_start_reg;
    len_t    s1_len_reg;
    logic    s1_order_reg;
    word_t   s1_value_reg;

    logic    done_reg;
    word_t   value_reg;
    word_t   frame_reg;
    logic    err_reg;

    logic    accept;
    desc_t   desc;
    word_t   value_next;
    word_t   frame_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= cmd;
            s1_frame_reg <= frame_in;
            s1_start_reg <= start_bit;
            s1_len_reg   <= bit_length;
            s1_order_reg <= byte_order;
            s1_value_reg <= insert_value;
        end
        if (s1_valid_reg)
        begin
            value_reg <= value_next;
            frame_reg <= frame_next;
            err_reg   <= desc.err;
        end
    end

    csfp_desc #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_desc (
        .start_bit  (s1_start_reg),
        .bit_length (s1_len_reg),
        .byte_order (s1_order_reg),
        .desc       (desc)
    );

    csfp_field u_field (
        .cmd          (s1_cmd_reg),
        .frame_in     (s1_frame_reg),
        .insert_value (s1_value_reg),
        .desc         (desc),
        .signal_value (value_next),
        .frame_out    (frame_next)
    );

    assign done         = done_reg;
    assign signal_value = value_reg;
    assign frame_out    = frame_reg;
    assign range_error  = err_reg;

    `CSFP_ASSERT_NEXT(a_accept_loads, accept, s1_valid_reg, "accepted transaction not loaded")
    `CSFP_ASSERT_NEXT(a_stage_to_done, s1_valid_reg, done, "loaded transaction gave no result")
    `CSFP_ASSERT_SAME(a_err_zero, done && range_error, signal_value == '0, "value on range error")
    `CSFP_ASSERT_NEXT(a_err_frame, s1_valid_reg && desc.err, frame_out == $past(s1_frame_reg),
        "frame altered on range error")

endmodule

`default_nettype wire

// File: dv/csfp_field_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN signal field access checker
// Watches the command and result channels of the pack/unpack core, works out
// the expected field value, frame and range flag for every accepted
// transaction and compares each result against the oldest expected one.
// ----------------------------------------------------------------------------
module csfp_field_checker
    import csfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  logic    cmd,
    input  word_t   frame_in,
    input  bitpos_t start_bit,
    input  len_t    bit_length,
    input  logic    byte_order,
    input  word_t   insert_value,
    input  logic    done,
    input  word_t   signal_value,
    input  word_t   frame_out,
    input  logic    range_error,
    output int      fail_count,
    output int      pending
);

    localparam int PAYLOAD_BITS = PAYLOAD_BYTES * BYTE_BITS;

    typedef struct {
        word_t value;
        word_t frame;
        logic  err;
    } field_result_t;

    field_result_t field_results_q[$];

    function automatic field_result_t compute_field_access(
        input logic    op,
        input word_t   frame,
        input bitpos_t sb,
        input len_t    len,
        input logic    order,
        input word_t   ins
    );
        field_result_t r;
        int            msb_pos;
        int            pos;
        int            lin;
        word_t         m;
        r.value = '0;
        r.frame = frame;
        if (order == ORDER_MOTOROLA)
            msb_pos = int'({sb[5:3], ~sb[2:0]});
        else
            msb_pos = int'(sb);
        r.err = (int'(len) == 0) || (int'(len) > WORD_BITS)
                || (msb_pos + int'(len) > PAYLOAD_BITS);
        if (!r.err)
        begin
            if (order == ORDER_INTEL)
            begin
                m = (int'(len) == WORD_BITS) ? '1 : ((word_t'(1) << len) - word_t'(1));
                if (op == CMD_GET)
                    r.value = (frame >> sb) & m;
                else
                    r.frame = (frame & ~(m << sb)) | ((ins & m) << sb);
            end
            else
            begin
                for (int k = 0; k < int'(len); k++)
                begin
                    pos = msb_pos + k;
                    lin = (pos & ~7) + (7 - (pos & 7));
                    if (op == CMD_GET)
                        r.value[int'(len) - 1 - k] = frame[lin];
                    else
                        r.frame[lin] = ins[int'(len) - 1 - k];
                end
            end
        end
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        field_result_t want;
        int            fails;
        fails = fail_count;
        if (rst_n)
        begin
            if (start && !busy)
                field_results_q.push_back(compute_field_access(cmd, frame_in, start_bit,
                    bit_length, byte_order, insert_value));
            if (done)
            begin
                if (field_results_q.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fails++;
                end
                else
                begin
                    want = field_results_q.pop_front();
                    if (signal_value !== want.value)
                    begin
                        $error("signal_value: expected %h, got %h", want.value, signal_value);
                        fails++;
                    end
                    if (frame_out !== want.frame)
                    begin
                        $error("frame_out: expected %h, got %h", want.frame, frame_out);
                        fails++;
                    end
                    if (range_error !== want.err)
                    begin
                        $error("range_error: expected %b, got %b", want.err, range_error);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= field_results_q.size();
    end

endmodule

// File: dv/can_signal_field_pack_unpack_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN signal field pack/unpack core testbench
// Drives directed edge cases of Intel and Motorola get/set transactions, then
// random mostly in-range descriptors with random payloads and idle gaps; the
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module can_signal_field_pack_unpack_core_tb;
    import csfp_pkg::*;

    localparam int PAYLOAD_BYTES = 8;
    localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * BYTE_BITS;
    localparam int RANDOM_ITEMS  = 1625;
    localparam int CYCLE_LIMIT   = 200000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    cmd;
    word_t   frame_in;
    bitpos_t start_bit;
    len_t    bit_length;
    logic    byte_order;
    word_t   insert_value;
    logic    done;
    word_t   signal_value;
    word_t   frame_out;
    logic    range_error;
    int      fail_count;
    int      pending;
    bit      idle_on;

    can_signal_field_pack_unpack_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .frame_in     (frame_in),
        .start_bit    (start_bit),
        .bit_length   (bit_length),
        .byte_order   (byte_order),
        .insert_value (insert_value),
        .done         (done),
        .signal_value (signal_value),
        .frame_out    (frame_out),
        .range_error  (range_error)
    );

    csfp_field_checker #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .frame_in     (frame_in),
        .start_bit    (start_bit),
        .bit_length   (bit_length),
        .byte_order   (byte_order),
        .insert_value (insert_value),
        .done         (done),
        .signal_value (signal_value),
        .frame_out    (frame_out),
        .range_error  (range_error),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic word_t rand_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        else if (pick < 10)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(
        input logic    op,
        input word_t   frame,
        input bitpos_t sb,
        input len_t    len,
        input logic    order,
        input word_t   ins
    );
        while (idle_on && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= op;
        frame_in     <= frame;
        start_bit    <= sb;
        bit_length   <= len;
        byte_order   <= order;
        insert_value <= ins;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        logic    op;
        logic    order;
        bitpos_t sb;
        len_t    len;
        int      pos;
        int      kind;
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_GET;
        frame_in     = '0;
        start_bit    = '0;
        bit_length   = '0;
        byte_order   = ORDER_INTEL;
        insert_value = '0;
        idle_on      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-width, single-bit and boundary fields in both orders
        send_item(CMD_GET, '1, 6'd0, 7'd64, ORDER_INTEL, '0);
        send_item(CMD_SET, '0, 6'd0, 7'd64, ORDER_INTEL, '1);
        send_item(CMD_GET, 64'h0123_4567_89AB_CDEF, 6'd7, 7'd64, ORDER_MOTOROLA, '0);
        send_item(CMD_SET, '1, 6'd7, 7'd64, ORDER_MOTOROLA, 64'h0123_4567_89AB_CDEF);
        send_item(CMD_GET, 64'h8000_0000_0000_0000, 6'd63, 7'd1, ORDER_INTEL, '0);
        send_item(CMD_SET, '0, 6'd63, 7'd1, ORDER_INTEL, '1);
        send_item(CMD_GET, 64'h0100_0000_0000_0000, 6'd56, 7'd1, ORDER_MOTOROLA, '0);
        send_item(CMD_SET, '1, 6'd56, 7'd1, ORDER_MOTOROLA, '0);
        send_item(CMD_GET, 64'hF000_0000_0000_0000, 6'd60, 7'd4, ORDER_INTEL, '0);
        send_item(CMD_GET, 64'hFEDC_BA98_7654_3210, 6'd3, 7'd12, ORDER_MOTOROLA, '0);
        send_item(CMD_SET, 64'hFEDC_BA98_7654_3210, 6'd3, 7'd12, ORDER_MOTOROLA, 64'hABC);
        send_item(CMD_GET, 64'hFEDC_BA98_7654_3210, 6'd0, 7'd57, ORDER_MOTOROLA, '0);
        // overrunning fields, zero and oversize lengths
        send_item(CMD_GET, '1, 6'd61, 7'd4, ORDER_INTEL, '0);
        send_item(CMD_SET, 64'h5555_AAAA_5555_AAAA, 6'd1, 7'd64, ORDER_INTEL, '1);
        send_item(CMD_GET, '1, 6'd56, 7'd2, ORDER_MOTOROLA, '0);
        send_item(CMD_SET, 64'h5555_AAAA_5555_AAAA, 6'd0, 7'd58, ORDER_MOTOROLA, '1);
        send_item(CMD_GET, '1, 6'd0, 7'd0, ORDER_INTEL, '0);
        send_item(CMD_SET, 64'h1234, 6'd8, 7'd0, ORDER_MOTOROLA, '1);
        send_item(CMD_GET, '1, 6'd0, 7'd65, ORDER_INTEL, '0);
        send_item(CMD_SET, 64'h1234, 6'd0, 7'd127, ORDER_INTEL, '1);
        send_item(CMD_GET, '1, 6'd63, 7'd127, ORDER_MOTOROLA, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_on = !(i >= 600 && i < 900);
            kind    = $urandom_range(99);
            op      = 1'($urandom_range(1));
            order   = 1'($urandom_range(1));
            if (kind < 88)
            begin
                if (kind < 8)
                    len = 7'd64;
                else if (kind < 50)
                    len = len_t'($urandom_range(16, 1));
                else
                    len = len_t'($urandom_range(64, 1));
                pos = $urandom_range(PAYLOAD_BITS - int'(len), 0);
                if (order == ORDER_MOTOROLA)
                    sb = {pos[5:3], ~pos[2:0]};
                else
                    sb = pos[5:0];
            end
            else
            begin
                sb  = bitpos_t'($urandom);
                len = len_t'($urandom);
            end
            send_item(op, rand_word(), sb, len, order, rand_word());
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
